@@ rtl/core/rwmf_pkg.sv @@
package rwmf_pkg;

  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned MaxRadiusDef = 3;

  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_t;

  localparam logic [12:0] WidthReset  = 13'd640;
  localparam logic [12:0] HeightReset = 13'd480;
  localparam logic [1:0]  RadiusReset = 2'd1;

endpackage

@@ rtl/core/rgb_window_median_filter.sv @@
// Flow: an accepted beat is written to the line store (S_WRITE); a pixel that completes a
// window then reads its n = (2r+1)^2 entries (S_READ), drains (S_HIST), scans the 256 bins
// (S_SCAN, S_TAIL) and raises out_tvalid in S_OUT; others return to S_IDLE. One pixel at a
// time: in_tready is high only in S_IDLE, so a new beat waits for the result and its stalls.
// Reset (rst_n low, synchronous) clears position and control, then a clearing pass zeroes the
// histograms before the first beat; the line store has no reset; registers go to 640x480, r=1.
module rgb_window_median_filter
  import rwmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_RADIUS = MaxRadiusDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  // center_x[11:0], center_y[23:12], median_red[31:24], median_green[39:32],
  // median_blue[47:40]
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [12:0] cfg_data
);

  // The line store holds 2*MAX_RADIUS+1 rows in slots chosen by row modulo
  // that count. Each window is read entry by entry into three histograms,
  // which are then scanned from value zero for the cumulative median.
  localparam int unsigned Slots = 2 * MAX_RADIUS + 1;
  localparam int unsigned SlotW = $clog2(Slots + 1);
  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned Depth = Slots * MAX_WIDTH;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(4 * MAX_RADIUS * MAX_RADIUS + 4 * MAX_RADIUS + 2);
  localparam int unsigned RadW  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned Bins  = 256;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_READ, S_HIST, S_SCAN, S_TAIL, S_OUT
  } state_t;

  logic [12:0] width_r, height_r;
  logic [1:0]  radius_r;
  state_t      state_r;
  logic [ColW-1:0] col_r;             // column of the next pixel
  logic [12:0] row_r;                 // row of the next pixel
  logic [SlotW-1:0] slot_r;           // row modulo Slots
  logic [23:0] pix_r;
  logic [11:0] cx_r, cy_r;
  logic [SlotW-1:0] rd_slot_r;
  logic [ColW-1:0]  rd_col_r;
  logic [RadW:0]    rd_c_r;           // column step of the window read
  logic [CntW-1:0]  left_r;           // entries still to be read
  logic             rd_v_r;
  logic [23:0]      rd_q_r;
  logic [23:0]      mem [Depth];
  logic [CntW-1:0]  hist_mem [3][Bins];
  logic [CntW-1:0]  hq_r [3];         // registered histogram read data
  logic             inc_v_r;          // increment stage holds a window entry
  logic [7:0]       inc_a_r [3];
  logic             lw_v_r;           // last increment write, for forwarding
  logic [7:0]       lw_a_r [3];
  logic [CntW-1:0]  lw_d_r [3];
  logic [CntW-1:0]  cum_r [3];
  logic [7:0]       med_r [3];
  logic [2:0]       found_r;
  logic [8:0]       scan_r;
  logic             sv_r;             // scan data stage valid
  logic [7:0]       sa_r;             // bin of the scan data stage

  logic [ColW:0]   w_eff;
  logic [12:0]     h_eff;
  logic [RadW-1:0] r_eff;
  logic [RadW:0]   side;
  logic [CntW-1:0] need, nwin;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic emit;
  logic h_clr;
  logic [7:0]      h_ra [3];
  logic [CntW-1:0] inc_d [3];
  logic [CntW-1:0] scan_sum [3];

  always_comb begin
    if (width_r == 13'd0) w_eff = (ColW+1)'(1);
    else if ({1'b0, width_r} > 14'(MAX_WIDTH)) w_eff = (ColW+1)'(MAX_WIDTH);
    else w_eff = (ColW+1)'(width_r);
    h_eff = (height_r == 13'd0) ? 13'd1 : height_r;
    r_eff = (32'(radius_r) > MAX_RADIUS) ? RadW'(MAX_RADIUS) : RadW'(radius_r);
    side  = {r_eff, 1'b1};
    nwin  = CntW'(side) * CntW'(side);
    need  = nwin >> 1;
    emit  = ((ColW+1)'(col_r) >= (ColW+1)'({r_eff, 1'b0})) &&
            (row_r >= 13'({r_eff, 1'b0}));
    wr_addr = AddrW'(slot_r) * AddrW'(MAX_WIDTH) + AddrW'(col_r);
    rd_addr = AddrW'(rd_slot_r) * AddrW'(MAX_WIDTH) + AddrW'(rd_col_r);
  end

  // A window entry is counted in the cycle after its histogram bin is read. The
  // bin written on the previous edge is not yet in that read, so it is
  // forwarded when the same value arrives back to back.
  always_comb begin
    h_clr = (state_r == S_CLEAR) || (state_r == S_SCAN);
    for (int ch = 0; ch < 3; ch++) begin
      h_ra[ch] = (state_r == S_SCAN) ? scan_r[7:0] : rd_q_r[8*ch +: 8];
      inc_d[ch] = ((lw_v_r && lw_a_r[ch] == inc_a_r[ch]) ? lw_d_r[ch] : hq_r[ch]) +
                  CntW'(1);
      scan_sum[ch] = cum_r[ch] + hq_r[ch];
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {med_r[2], med_r[1], med_r[0], cy_r, cx_r};

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) mem[wr_addr] <= pix_r;
    rd_q_r <= mem[rd_addr];
  end

  // Histograms: increment during the read, clear entry by entry during scan
  // and during the pass after reset.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (h_clr) hist_mem[ch][scan_r[7:0]] <= '0;
      else if (inc_v_r) hist_mem[ch][inc_a_r[ch]] <= inc_d[ch];
      hq_r[ch] <= hist_mem[ch][h_ra[ch]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      width_r  <= WidthReset;
      height_r <= HeightReset;
      radius_r <= RadiusReset;
      col_r    <= '0;
      row_r    <= '0;
      slot_r   <= '0;
      rd_v_r   <= 1'b0;
      inc_v_r  <= 1'b0;
      lw_v_r   <= 1'b0;
      sv_r     <= 1'b0;
      scan_r   <= '0;
    end else begin
      rd_v_r  <= (state_r == S_READ);
      inc_v_r <= rd_v_r;
      lw_v_r  <= inc_v_r;
      sv_r    <= (state_r == S_SCAN);
      sa_r    <= scan_r[7:0];
      for (int ch = 0; ch < 3; ch++) begin
        inc_a_r[ch] <= rd_q_r[8*ch +: 8];
        lw_a_r[ch]  <= inc_a_r[ch];
        lw_d_r[ch]  <= inc_d[ch];
      end
      // The scan data stage accumulates each channel and marks the first bin
      // where the running count passes half the window.
      if (sv_r) begin
        for (int ch = 0; ch < 3; ch++) begin
          if (!found_r[ch] && (scan_sum[ch] > need)) begin
            found_r[ch] <= 1'b1;
            med_r[ch]   <= sa_r;
          end
          cum_r[ch] <= scan_sum[ch];
        end
      end
      unique case (state_r)
        S_CLEAR: begin
          scan_r <= scan_r + 1'b1;
          if (scan_r == 9'd255) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              REG_WIDTH:  width_r  <= cfg_data;
              REG_HEIGHT: height_r <= cfg_data;
              REG_RADIUS: radius_r <= cfg_data[1:0];
              default: ;
            endcase
            if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                cfg_index == REG_RADIUS) begin
              col_r  <= '0;
              row_r  <= '0;
              slot_r <= '0;
            end
          end else if (in_tvalid) begin
            pix_r   <= in_tdata;
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          cx_r <= 12'(col_r - ColW'(r_eff));
          cy_r <= 12'(row_r - 13'(r_eff));
          rd_slot_r <= slot_r;
          rd_col_r  <= col_r - ColW'({r_eff, 1'b0});
          rd_c_r <= '0;
          left_r <= nwin;
          if (emit) state_r <= S_READ;
          else state_r <= S_IDLE;
          if ((ColW+1)'(col_r) + (ColW+1)'(1) >= w_eff) begin
            col_r <= '0;
            if (row_r + 13'd1 >= h_eff) begin
              row_r  <= '0;
              slot_r <= '0;
            end else begin
              row_r  <= row_r + 13'd1;
              slot_r <= (slot_r == SlotW'(Slots - 1)) ? '0 : slot_r + 1'b1;
            end
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        S_READ: begin
          // One entry per cycle; columns run fastest, rows step upward.
          left_r <= left_r - 1'b1;
          if (rd_c_r + 1'b1 == side) begin
            rd_c_r   <= '0;
            rd_col_r <= rd_col_r - ColW'(rd_c_r);
            rd_slot_r <= (rd_slot_r == '0) ? SlotW'(Slots - 1) : rd_slot_r - 1'b1;
          end else begin
            rd_c_r   <= rd_c_r + 1'b1;
            rd_col_r <= rd_col_r + 1'b1;
          end
          if (left_r == CntW'(1)) state_r <= S_HIST;
        end
        S_HIST: begin
          // Wait until the last window entry has been counted.
          scan_r  <= '0;
          found_r <= '0;
          for (int ch = 0; ch < 3; ch++) cum_r[ch] <= '0;
          if (!rd_v_r && !inc_v_r) state_r <= S_SCAN;
        end
        S_SCAN: begin
          scan_r <= scan_r + 1'b1;
          if (scan_r == 9'd255) state_r <= S_TAIL;
        end
        S_TAIL: begin
          // The last bin's data is evaluated on this edge.
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready && !cfg_ready)
    else $error("accept while busy");
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> found_r == 3'b111)
    else $error("median missing");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && $past(state_r) == S_WRITE |-> (ColW+1)'(col_r) < w_eff)
    else $error("column out of range");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

// Scoreboard for the median filter. It keeps its own copy of the line store,
// the frame position and the registers, and it predicts one result for every
// pixel that completes a window.
class median_scoreboard;
  typedef struct packed {
    logic [11:0] cx;
    logic [11:0] cy;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } median_beat_t;

  localparam int unsigned Slots = 2 * rwmf_pkg::MaxRadiusDef + 1;
  localparam int unsigned Cols  = rwmf_pkg::MaxWidthDef;

  bit [23:0]    rows_seen[Slots * Cols];
  bit [12:0]    width_reg;
  bit [12:0]    height_reg;
  bit [1:0]     radius_reg;
  int unsigned  col_pos;
  int unsigned  row_pos;
  median_beat_t medians_due[$];
  int           errors;

  function new();
    width_reg  = rwmf_pkg::WidthReset;
    height_reg = rwmf_pkg::HeightReset;
    radius_reg = rwmf_pkg::RadiusReset;
    col_pos    = 0;
    row_pos    = 0;
    errors     = 0;
  endfunction

  // A register write restarts the frame; an unknown index changes nothing.
  function void write_reg(logic [1:0] idx, logic [12:0] val);
    case (idx)
      rwmf_pkg::REG_WIDTH: begin
        width_reg = val;
      end
      rwmf_pkg::REG_HEIGHT: begin
        height_reg = val;
      end
      rwmf_pkg::REG_RADIUS: begin
        radius_reg = val[1:0];
      end
      default: begin
        return;
      end
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Median of one channel over the window that starts at column x0 and ends at row y.
  function bit [7:0] channel_median(int unsigned x0, int unsigned y, int unsigned rad,
                                    int unsigned sh);
    int unsigned hist[256];
    int unsigned side;
    int unsigned cum;
    int unsigned slot;
    bit [23:0]   px;
    side = 2 * rad + 1;
    cum  = 0;
    foreach (hist[i]) hist[i] = 0;
    for (int d = 0; d < side; d++) begin
      slot = (y % Slots + Slots - d) % Slots;
      for (int c = 0; c < side; c++) begin
        px = rows_seen[slot * Cols + (x0 + c) % Cols];
        hist[(px >> sh) & 8'hFF]++;
      end
    end
    for (int v = 0; v < 256; v++) begin
      cum += hist[v];
      if (cum > (side * side) / 2) return v[7:0];
    end
    return 8'hFF;
  endfunction

  function void note_pixel(bit [23:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned rad;
    median_beat_t m;
    w   = (width_reg == 0) ? 1 : ((width_reg > Cols) ? Cols : width_reg);
    h   = (height_reg == 0) ? 1 : height_reg;
    rad = radius_reg;
    rows_seen[(row_pos % Slots) * Cols + col_pos % Cols] = px;
    if (col_pos >= 2 * rad && row_pos >= 2 * rad) begin
      m.cx    = 12'(col_pos - rad);
      m.cy    = 12'(row_pos - rad);
      m.red   = channel_median(col_pos - 2 * rad, row_pos, rad, 0);
      m.green = channel_median(col_pos - 2 * rad, row_pos, rad, 8);
      m.blue  = channel_median(col_pos - 2 * rad, row_pos, rad, 16);
      medians_due.push_back(m);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function int pending();
    return medians_due.size();
  endfunction

  task report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task check_result(logic [47:0] beat);
    median_beat_t m;
    if (medians_due.size() == 0) begin
      report("unexpected result beat, center_x", beat[11:0], -1);
      return;
    end
    m = medians_due.pop_front();
    if (beat[11:0] !== m.cx)     report("center_x", beat[11:0], m.cx);
    if (beat[23:12] !== m.cy)    report("center_y", beat[23:12], m.cy);
    if (beat[31:24] !== m.red)   report("median_red", beat[31:24], m.red);
    if (beat[39:32] !== m.green) report("median_green", beat[39:32], m.green);
    if (beat[47:40] !== m.blue)  report("median_blue", beat[47:40], m.blue);
  endtask
endclass

module tb;
  import rwmf_pkg::*;

  // Index that names no register; writing it must change nothing.
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  // Quiet cycles after the last result before a register write: covers the
  // slowest pixel (radius 3 window read plus histogram scan).
  localparam int SettleCycles = 400;
  // Cycles without any accepted beat before the run is declared hung. It
  // has to outlast the long receiver hold-off below several times.
  localparam int StallLimit   = 20000;
  localparam int HoldOffCycles = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [12:0] cfg_data;

  median_scoreboard medians;
  int  burst_left;
  int  pixels_sent;
  bit  hold_request;
  bit  holding;
  int  idle_cycles;

  rgb_window_median_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: a stall pattern of its own, with stretches of full readiness,
  // plus one long hold-off on request so that the pipeline backs up into the
  // input side. The request is taken once.
  initial begin
    int mode;
    int mode_left;
    int held;
    out_tready = 1'b0;
    holding    = 1'b0;
    mode       = 0;
    mode_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !holding) begin
        holding      = 1'b1;
        held         = 0;
        hold_request = 1'b0;
      end
      if (holding) begin
        out_tready = 1'b0;
        held++;
        if (held >= HoldOffCycles) begin
          holding = 1'b0;
        end
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = ($urandom_range(0, 3) != 0);
          default: out_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Every accepted result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) medians.check_result(out_tdata);
  end

  // Watchdog: any accepted beat on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("rgb_window_median_filter test failed");
        $finish;
      end
    end
  end

  task write_cfg(logic [CfgIdxW-1:0] idx, logic [12:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    medians.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sender: one pixel beat. Bursts of random length alternate with random
  // gaps; valid stays high across a burst.
  task send_pixel(logic [23:0] px);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata  = px;
    do @(posedge clk); while (!in_tready);
    medians.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Wait until every predicted result has come, then let a pixel that
  // completes no window finish too.
  task drain();
    in_tvalid = 1'b0;
    while (medians.pending() > 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task set_frame(int w, int h, int rad);
    drain();
    write_cfg(REG_WIDTH, 13'(w));
    write_cfg(REG_HEIGHT, 13'(h));
    write_cfg(REG_RADIUS, 13'(rad));
  endtask

  task random_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(24'($urandom()));
  endtask

  initial begin
    logic [23:0] extremes[8];
    medians      = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_WIDTH;
    cfg_data     = '0;
    hold_request = 1'b0;
    burst_left   = 0;
    pixels_sent  = 0;
    idle_cycles  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: a 5 x 4 frame with radius 1 fed with all-zero, all-one and
    // single-channel extremes, so the medians land on the byte limits.
    extremes = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
                 24'hFF0000, 24'hFFFFFF, 24'h000000, 24'h7F80FF};
    set_frame(5, 4, 1);
    for (int i = 0; i < 20; i++) send_pixel(extremes[i % 8]);

    // Radius zero passes every pixel through; zero width and height act as one.
    set_frame(0, 0, 0);
    random_pixels(6);
    // Width beyond the maximum is clamped; height at its largest code.
    set_frame(8191, 8191, 0);
    random_pixels(10);
    set_frame(4096, 2, 0);
    random_pixels(8);

    // An unknown register index is ignored and must not restart the frame.
    set_frame(6, 5, 1);
    random_pixels(9);
    write_cfg(RegUnused, 13'h1FFF);
    random_pixels(30);

    // Largest window: one result per 7 x 7 frame, a few per 9 x 8 frame.
    set_frame(7, 7, 3);
    random_pixels(100);
    set_frame(9, 8, 3);
    random_pixels(150);

    // Long receiver hold-off while the sender keeps offering pixels.
    set_frame(16, 6, 1);
    hold_request = 1'b1;
    random_pixels(150);
    // Sender pause in mid-frame until every result is out.
    while (medians.pending() > 0) @(negedge clk);
    random_pixels(150);

    set_frame(12, 10, 2);
    random_pixels(250);

    // Random frame shapes and radii, mostly small sizes.
    while (pixels_sent < 1900) begin
      set_frame($urandom_range(1, 20), $urandom_range(1, 12), $urandom_range(0, 3));
      random_pixels($urandom_range(100, 200));
    end

    in_tvalid = 1'b0;
    while (medians.pending() > 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (medians.errors == 0 && medians.pending() == 0) begin
      $display("rgb_window_median_filter test passed");
    end else begin
      $display("rgb_window_median_filter test failed");
    end
    $finish;
  end
endmodule
